### rtl/gil_pkg.sv
package gil_pkg;

  localparam int unsigned MaxIntervalsDef = 64;

  localparam int unsigned CpW     = 21;
  localparam int unsigned BaseW   = 24;
  localparam int unsigned GlyphW  = 25;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  localparam logic [CfgIdxW-1:0] CFG_INTERVAL_COUNT   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GLYPH_TABLE_BASE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECORD_FORMAT    = 2'd2;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic [CpW-1:0] CP_LSQUO  = 21'h02018;
  localparam logic [CpW-1:0] CP_RSQUO  = 21'h02019;
  localparam logic [CpW-1:0] CP_APOS   = 21'h00027;
  localparam logic [CpW-1:0] CP_LDQUO  = 21'h0201C;
  localparam logic [CpW-1:0] CP_RDQUO  = 21'h0201D;
  localparam logic [CpW-1:0] CP_QUOT   = 21'h00022;
  localparam logic [CpW-1:0] CP_NBSP   = 21'd160;
  localparam logic [CpW-1:0] CP_SPACE  = 21'd32;
  localparam logic [CpW-1:0] CP_ENDASH = 21'h02013;
  localparam logic [CpW-1:0] CP_EMDASH = 21'h02014;
  localparam logic [CpW-1:0] CP_HYPHEN = 21'h0002D;

  localparam logic [AddrW-1:0] STRIDE_WIDE   = 32'd16;
  localparam logic [AddrW-1:0] STRIDE_NARROW = 32'd13;

  typedef struct packed {
    logic [CpW-1:0]   first;
    logic [CpW-1:0]   last;
    logic [BaseW-1:0] base;
  } interval_t;

  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] cp;
  } subst_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADDR,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    logic write;
    logic scan;
    logic start_sub;
    logic set_miss;
    logic calc_addr;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic sub_avail;
    logic fb_done;
    logic out_busy;
  } dp_status_t;

  function automatic subst_t substitute(input logic [CpW-1:0] cp);
    subst_t s;
    s.valid = 1'b1;
    s.cp    = '0;
    if (cp inside {CP_LSQUO, CP_RSQUO}) begin
      s.cp = CP_APOS;
    end else if (cp inside {CP_LDQUO, CP_RDQUO}) begin
      s.cp = CP_QUOT;
    end else if (cp == CP_NBSP) begin
      s.cp = CP_SPACE;
    end else if (cp inside {CP_ENDASH, CP_EMDASH}) begin
      s.cp = CP_HYPHEN;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

### rtl/gil_ctrl.sv
module gil_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                func_i,
  output logic                in_ready_o,
  input  gil_pkg::dp_status_t status_i,
  output gil_pkg::ctrl_cmd_t  cmd_o
);
  import gil_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && func_i == FUNC_LOOKUP) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          state_d = ST_ADDR;
        end else if (status_i.miss && !(status_i.sub_avail && !status_i.fb_done)) begin
          state_d = ST_EMIT;
        end
      end
      ST_ADDR: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = (func_i == FUNC_LOOKUP);
          cmd_o.write = (func_i == FUNC_LOAD);
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.miss) begin
          if (status_i.sub_avail && !status_i.fb_done) begin
            cmd_o.start_sub = 1'b1;
          end else begin
            cmd_o.set_miss = 1'b1;
          end
        end
      end
      ST_ADDR: cmd_o.calc_addr = 1'b1;
      ST_EMIT: cmd_o.emit = !status_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

### rtl/gil_dp.sv
module gil_dp #(
  parameter int unsigned MAX_INTERVALS = gil_pkg::MaxIntervalsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gil_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gil_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic [gil_pkg::SlotW-1:0]     entry_index_i,
  input  logic [gil_pkg::CpW-1:0]       range_first_i,
  input  logic [gil_pkg::CpW-1:0]       range_last_i,
  input  logic [gil_pkg::BaseW-1:0]     range_glyph_base_i,
  input  logic [gil_pkg::CpW-1:0]       code_point_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          found_o,
  output logic                          used_fallback_o,
  output logic [gil_pkg::CpW-1:0]       resolved_code_point_o,
  output logic [gil_pkg::GlyphW-1:0]    glyph_index_o,
  output logic [gil_pkg::AddrW-1:0]     record_address_o,
  input  gil_pkg::ctrl_cmd_t            cmd_i,
  output gil_pkg::dp_status_t           status_o
);
  import gil_pkg::*;

  localparam int unsigned IdxW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int unsigned CntW = $clog2(MAX_INTERVALS + 1);

  // configuration
  logic [CountW-1:0] count_q;
  logic [AddrW-1:0]  base_q;
  logic              fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      base_q  <= '0;
      fmt_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_INTERVAL_COUNT:   count_q <= cfg_wdata_i[CountW-1:0];
        CFG_GLYPH_TABLE_BASE: base_q  <= cfg_wdata_i;
        CFG_RECORD_FORMAT:    fmt_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] n;
  assign n = (32'(count_q) > MAX_INTERVALS) ? CntW'(MAX_INTERVALS) : CntW'(count_q);

  // interval table
  interval_t mem [MAX_INTERVALS];
  interval_t rdata_q;
  logic      slot_ok;
  logic [CntW-1:0] k_q;

  assign slot_ok = 32'(entry_index_i) < MAX_INTERVALS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && slot_ok) begin
      mem[IdxW'(entry_index_i)] <= '{first: range_first_i, last: range_last_i,
                                     base: range_glyph_base_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[k_q[IdxW-1:0]];
  end

  // search
  logic              pend_q;
  logic              fb_q;
  logic              found_q;
  logic [CpW-1:0]    cp_q;
  logic [CpW-1:0]    key_q;
  logic [GlyphW-1:0] gidx_q;
  logic [AddrW-1:0]  addr_q;
  logic              in_range;
  subst_t            sub;

  assign sub      = substitute(cp_q);
  assign in_range = (key_q >= rdata_q.first) && (key_q <= rdata_q.last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.start || cmd_i.start_sub) begin
      k_q    <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.scan) begin
      pend_q <= (k_q < n);
      if (k_q < n) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cp_q    <= code_point_i;
      key_q   <= code_point_i;
      fb_q    <= 1'b0;
      found_q <= 1'b0;
    end else if (cmd_i.start_sub) begin
      key_q <= sub.cp;
      fb_q  <= 1'b1;
    end else if (cmd_i.set_miss) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan && status_o.hit) begin
      found_q <= 1'b1;
      gidx_q  <= GlyphW'(rdata_q.base) + GlyphW'(key_q - rdata_q.first);
    end
    if (cmd_i.calc_addr) begin
      addr_q <= base_q + 32'(gidx_q) * (fmt_q ? STRIDE_WIDE : STRIDE_NARROW);
    end
  end

  // result register
  logic              out_valid_q;
  logic              out_found_q;
  logic              out_fb_q;
  logic [CpW-1:0]    out_cp_q;
  logic [GlyphW-1:0] out_gidx_q;
  logic [AddrW-1:0]  out_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_found_q <= found_q;
      out_fb_q    <= found_q & fb_q;
      out_cp_q    <= found_q ? key_q : '0;
      out_gidx_q  <= found_q ? gidx_q : '0;
      out_addr_q  <= found_q ? addr_q : '0;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign found_o               = out_found_q;
  assign used_fallback_o       = out_fb_q;
  assign resolved_code_point_o = out_cp_q;
  assign glyph_index_o         = out_gidx_q;
  assign record_address_o      = out_addr_q;

  assign status_o.hit       = pend_q && in_range;
  assign status_o.miss      = !pend_q && (k_q >= n);
  assign status_o.sub_avail = sub.valid;
  assign status_o.fb_done   = fb_q;
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  a_pend_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> k_q != '0)
    else $error("pending compare without an issued read");

  a_fb_needs_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fb_q |-> out_found_q)
    else $error("fallback flagged on a miss");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |->
      (out_cp_q == '0 && out_gidx_q == '0 && out_addr_q == '0))
    else $error("miss result not cleared");

  a_no_emit_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before it was taken");

endmodule

### rtl/glyph_interval_lookup_top.sv
// Glyph interval lookup. A load request (func 0) writes one interval entry into
// the table in the cycle it is accepted. A lookup request (func 1) scans entries
// 0 .. n-1, n = min(interval_count, MAX_INTERVALS), one table read per cycle,
// from a memory with a separate write port and registered read data; the first
// matching entry wins. A miss on a quote, no-break space or dash repeats the
// scan once with the ASCII substitute. A lookup goes through acceptance, the
// scan, an address step on a hit and the output register, whose write waits
// while an earlier result has not been taken. The result sits in an output
// register, so the next request is taken while it waits. Table entries are
// undefined until loaded; no clearing pass is run after reset.
module glyph_interval_lookup_top #(
  parameter int unsigned MAX_INTERVALS = gil_pkg::MaxIntervalsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gil_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gil_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [gil_pkg::SlotW-1:0]   entry_index_i,
  input  logic [gil_pkg::CpW-1:0]     range_first_i,
  input  logic [gil_pkg::CpW-1:0]     range_last_i,
  input  logic [gil_pkg::BaseW-1:0]   range_glyph_base_i,
  input  logic [gil_pkg::CpW-1:0]     code_point_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic                        used_fallback_o,
  output logic [gil_pkg::CpW-1:0]     resolved_code_point_o,
  output logic [gil_pkg::GlyphW-1:0]  glyph_index_o,
  output logic [gil_pkg::AddrW-1:0]   record_address_o
);
  import gil_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  gil_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gil_dp #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .entry_index_i         (entry_index_i),
    .range_first_i         (range_first_i),
    .range_last_i          (range_last_i),
    .range_glyph_base_i    (range_glyph_base_i),
    .code_point_i          (code_point_i),
    .out_ready_i           (out_ready_i),
    .out_valid_o           (out_valid_o),
    .found_o               (found_o),
    .used_fallback_o       (used_fallback_o),
    .resolved_code_point_o (resolved_code_point_o),
    .glyph_index_o         (glyph_index_o),
    .record_address_o      (record_address_o),
    .cmd_i                 (cmd),
    .status_o              (status)
  );

endmodule

### test/glyph_interval_lookup_top_tb.sv
module glyph_interval_lookup_top_tb;
  import gil_pkg::*;

  localparam logic [CpW-1:0] MaxCp        = 21'h10FFFF;
  localparam int unsigned    SettleCycles = 2 * MaxIntervalsDef + 12;
  localparam int unsigned    NumPhases    = 26;
  localparam int unsigned    PhaseItems   = 72;
  localparam int unsigned    CycleLimit   = 1_500_000;

  typedef struct packed {
    logic             func;
    logic [SlotW-1:0] slot;
    logic [CpW-1:0]   first;
    logic [CpW-1:0]   last;
    logic [BaseW-1:0] gbase;
    logic [CpW-1:0]   cp;
  } request_t;

  typedef struct packed {
    logic              found;
    logic              fallback;
    logic [CpW-1:0]    resolved;
    logic [GlyphW-1:0] glyph;
    logic [AddrW-1:0]  address;
  } lookup_result_t;

  class glyph_lookup_tracker;
    interval_t         intervals [MaxIntervalsDef];
    logic [CountW-1:0] interval_count;
    logic [AddrW-1:0]  table_base;
    logic              wide_records;
    lookup_result_t    awaited_results [$];
    int unsigned       mismatches;

    function new();
      interval_count = '0;
      table_base     = '0;
      wide_records   = 1'b1;
      mismatches     = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_INTERVAL_COUNT:   interval_count = data[CountW-1:0];
        CFG_GLYPH_TABLE_BASE: table_base = data;
        CFG_RECORD_FORMAT:    wide_records = data[0];
        default: ;
      endcase
    endfunction

    function bit ascii_fallback(logic [CpW-1:0] cp, output logic [CpW-1:0] alt);
      alt = '0;
      case (cp)
        CP_LSQUO, CP_RSQUO:   alt = CP_APOS;
        CP_LDQUO, CP_RDQUO:   alt = CP_QUOT;
        CP_NBSP:              alt = CP_SPACE;
        CP_ENDASH, CP_EMDASH: alt = CP_HYPHEN;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // first matching interval wins
    function bit scan_intervals(logic [CpW-1:0] cp, output logic [GlyphW-1:0] glyph);
      int unsigned n;
      int unsigned k;
      glyph = '0;
      n = (interval_count > MaxIntervalsDef) ? MaxIntervalsDef : int'(interval_count);
      for (k = 0; k < n; k++) begin
        if (cp >= intervals[k].first && cp <= intervals[k].last) begin
          glyph = GlyphW'(intervals[k].base) + GlyphW'(cp - intervals[k].first);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(request_t req);
      lookup_result_t    res;
      logic [CpW-1:0]    alt;
      logic [GlyphW-1:0] glyph;
      logic [AddrW-1:0]  stride;
      if (req.func == FUNC_LOAD) begin
        if (req.slot < MaxIntervalsDef) begin
          intervals[req.slot].first = req.first;
          intervals[req.slot].last  = req.last;
          intervals[req.slot].base  = req.gbase;
        end
        return;
      end
      res = '0;
      if (scan_intervals(req.cp, glyph)) begin
        res.found    = 1'b1;
        res.resolved = req.cp;
      end else if (ascii_fallback(req.cp, alt) && scan_intervals(alt, glyph)) begin
        res.found    = 1'b1;
        res.fallback = 1'b1;
        res.resolved = alt;
      end
      if (res.found) begin
        stride      = wide_records ? STRIDE_WIDE : STRIDE_NARROW;
        res.glyph   = glyph;
        res.address = table_base + AddrW'(glyph) * stride;
      end
      awaited_results.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [AddrW-1:0] got, logic [AddrW-1:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0h want %0h", name, got, want));
      end
    endtask

    task check_result(lookup_result_t got);
      lookup_result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result, code point %0h", got.resolved));
        return;
      end
      want = awaited_results.pop_front();
      compare_field("found", AddrW'(got.found), AddrW'(want.found));
      compare_field("used_fallback", AddrW'(got.fallback), AddrW'(want.fallback));
      compare_field("resolved_code_point", AddrW'(got.resolved), AddrW'(want.resolved));
      compare_field("glyph_index", AddrW'(got.glyph), AddrW'(want.glyph));
      compare_field("record_address", got.address, want.address);
    endtask

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                func_i;
  logic [SlotW-1:0]    entry_index_i;
  logic [CpW-1:0]      range_first_i;
  logic [CpW-1:0]      range_last_i;
  logic [BaseW-1:0]    range_glyph_base_i;
  logic [CpW-1:0]      code_point_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                found_o;
  logic                used_fallback_o;
  logic [CpW-1:0]      resolved_code_point_o;
  logic [GlyphW-1:0]   glyph_index_o;
  logic [AddrW-1:0]    record_address_o;

  glyph_lookup_tracker tracker;
  interval_t           loaded_intervals [MaxIntervalsDef];
  int unsigned         active_slots = 0;
  bit                  gaps_on = 1'b1;
  bit                  stalls_on = 1'b1;
  int unsigned         stall_left = 0;
  int unsigned         cycles = 0;

  glyph_interval_lookup_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_index_i           (cfg_index_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .func_i                (func_i),
    .entry_index_i         (entry_index_i),
    .range_first_i         (range_first_i),
    .range_last_i          (range_last_i),
    .range_glyph_base_i    (range_glyph_base_i),
    .code_point_i          (code_point_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .found_o               (found_o),
    .used_fallback_o       (used_fallback_o),
    .resolved_code_point_o (resolved_code_point_o),
    .glyph_index_o         (glyph_index_o),
    .record_address_o      (record_address_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.note_request('{func_i, entry_index_i, range_first_i, range_last_i,
                               range_glyph_base_i, code_point_i});
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_result('{found_o, used_fallback_o, resolved_code_point_o,
                               glyph_index_o, record_address_o});
      end
    end
  end

  always @(negedge clk_i) begin
    if (stalls_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16);
    end
    if (stall_left != 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  function automatic logic [CpW-1:0] special_code_point();
    case ($urandom_range(0, 10))
      0:       return CP_LSQUO;
      1:       return CP_RSQUO;
      2:       return CP_APOS;
      3:       return CP_LDQUO;
      4:       return CP_RDQUO;
      5:       return CP_QUOT;
      6:       return CP_NBSP;
      7:       return CP_SPACE;
      8:       return CP_ENDASH;
      9:       return CP_EMDASH;
      default: return CP_HYPHEN;
    endcase
  endfunction

  function automatic interval_t random_interval();
    interval_t      iv;
    logic [CpW-1:0] anchor;
    int unsigned    top;
    case ($urandom_range(0, 7))
      0:       iv.base = '0;
      1:       iv.base = '1;
      default: iv.base = BaseW'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: begin
        // empty: last below first
        iv.first = CpW'($urandom_range(1, MaxCp));
        iv.last  = iv.first - CpW'($urandom_range(1, iv.first));
      end
      1, 2: begin
        anchor   = special_code_point();
        iv.first = anchor - CpW'($urandom_range(0, 3));
        iv.last  = anchor + CpW'($urandom_range(0, 3));
      end
      3: begin
        iv.first = CpW'($urandom_range(0, MaxCp));
        iv.last  = CpW'($urandom_range(iv.first, MaxCp));
      end
      default: begin
        iv.first = CpW'($urandom_range(0, 1) ? $urandom_range(0, 16'hFFFF)
                                             : $urandom_range(0, MaxCp));
        top      = iv.first + $urandom_range(0, 63);
        iv.last  = (top > MaxCp) ? MaxCp : CpW'(top);
      end
    endcase
    return iv;
  endfunction

  function automatic logic [CpW-1:0] pick_code_point();
    int unsigned kind;
    interval_t   iv;
    kind = $urandom_range(0, 9);
    if (active_slots == 0 && kind <= 5) begin
      kind = 9;
    end
    iv = loaded_intervals[$urandom_range(0, (active_slots == 0) ? 0 : active_slots - 1)];
    case (kind)
      0, 1, 2, 3, 4: begin
        return (iv.last >= iv.first) ? CpW'($urandom_range(iv.first, iv.last)) : iv.first;
      end
      5: begin
        if ($urandom_range(0, 1) == 0) begin
          return (iv.first == 0) ? '0 : iv.first - 1'b1;
        end
        return (iv.last >= MaxCp) ? MaxCp : iv.last + 1'b1;
      end
      6, 7:    return special_code_point();
      8:       return $urandom_range(0, 1) ? MaxCp : '0;
      default: return CpW'($urandom_range(0, MaxCp));
    endcase
  endfunction

  function automatic request_t scrambled_request();
    request_t req;
    req.func  = FUNC_LOAD;
    req.slot  = SlotW'($urandom);
    req.first = CpW'($urandom_range(0, MaxCp));
    req.last  = CpW'($urandom_range(0, MaxCp));
    req.gbase = BaseW'($urandom);
    req.cp    = CpW'($urandom_range(0, MaxCp));
    return req;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(request_t req);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    func_i             = req.func;
    entry_index_i      = req.slot;
    range_first_i      = req.first;
    range_last_i       = req.last;
    range_glyph_base_i = req.gbase;
    code_point_i       = req.cp;
    in_valid_i         = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_load(logic [SlotW-1:0] slot, interval_t iv);
    request_t req;
    req       = scrambled_request();
    req.func  = FUNC_LOAD;
    req.slot  = slot;
    req.first = iv.first;
    req.last  = iv.last;
    req.gbase = iv.base;
    loaded_intervals[slot] = iv;
    send_request(req);
  endtask

  task automatic send_lookup(logic [CpW-1:0] cp);
    request_t req;
    req      = scrambled_request();
    req.func = FUNC_LOOKUP;
    req.cp   = cp;
    send_request(req);
  endtask

  task automatic set_register(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    tracker.write_register(idx, data);
    if (idx == CFG_INTERVAL_COUNT) begin
      active_slots = (data > MaxIntervalsDef) ? MaxIntervalsDef : data;
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // drained: nothing awaited, and a trailing load has had time to land
  task automatic settle();
    in_valid_i = 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    int unsigned    phase;
    int unsigned    slot;
    logic [CfgW-1:0] count_val;
    logic [CfgW-1:0] base_val;
    tracker            = new();
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CFG_INTERVAL_COUNT;
    cfg_wdata_i        = '0;
    in_valid_i         = 1'b0;
    out_ready_i        = 1'b0;
    func_i             = FUNC_LOAD;
    entry_index_i      = '0;
    range_first_i      = '0;
    range_last_i       = '0;
    range_glyph_base_i = '0;
    code_point_i       = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // nothing searched with the reset count
    send_lookup(CP_LSQUO);
    settle();
    set_register(CFG_INTERVAL_COUNT, 32'd4);
    set_register(CFG_GLYPH_TABLE_BASE, 32'hFFFF_FFFF);
    set_register(CFG_RECORD_FORMAT, 32'd0);
    send_load(6'd0, '{CP_APOS, CP_APOS, 24'd0});
    send_load(6'd1, '{CP_HYPHEN, CP_HYPHEN, 24'hFFFFFF});
    send_load(6'd2, '{21'h100000, MaxCp, 24'hFFFFFF});
    send_load(6'd3, '{MaxCp, 21'd0, 24'h123456});
    send_lookup(CP_APOS);
    send_lookup(CP_LSQUO);
    send_lookup(CP_RSQUO);
    send_lookup(CP_LDQUO);
    send_lookup(CP_RDQUO);
    send_lookup(CP_NBSP);
    send_lookup(CP_ENDASH);
    send_lookup(CP_EMDASH);
    send_lookup(MaxCp);
    send_lookup(21'd0);
    send_lookup(21'h100000);

    // fill the whole table before any count can reach past slot 3
    for (slot = 0; slot < MaxIntervalsDef; slot++) begin
      send_load(SlotW'(slot), random_interval());
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      settle();
      case (phase)
        0:       count_val = 32'd64;
        1:       count_val = 32'd127;
        2:       count_val = 32'd1;
        3:       count_val = 32'd0;
        4:       count_val = 32'd65;
        default: begin
          case ($urandom_range(0, 5))
            0:       count_val = 32'd0;
            1:       count_val = $urandom_range(65, 127);
            2, 3:    count_val = $urandom_range(1, 16);
            default: count_val = $urandom_range(1, 64);
          endcase
        end
      endcase
      if (phase == 0) begin
        base_val = '0;
      end else if (phase == 1 || $urandom_range(0, 5) == 0) begin
        base_val = '1;
      end else begin
        base_val = $urandom;
      end
      set_register(CFG_INTERVAL_COUNT, count_val);
      set_register(CFG_GLYPH_TABLE_BASE, base_val);
      set_register(CFG_RECORD_FORMAT,
                   (phase < 2) ? CfgW'(phase == 0) : CfgW'($urandom_range(0, 1)));
      if (phase + 3 >= NumPhases) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      repeat (PhaseItems) begin
        if ($urandom_range(0, 6) == 0) begin
          send_load(SlotW'($urandom_range(0, MaxIntervalsDef - 1)), random_interval());
        end else begin
          send_lookup(pick_code_point());
        end
      end
    end

    settle();
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/gil_pkg.sv
rtl/gil_ctrl.sv
rtl/gil_dp.sv
rtl/glyph_interval_lookup_top.sv
test/glyph_interval_lookup_top_tb.sv
